// ===== design/ccb_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block keystream package
// State type, sigma constants, register indexes and the quarter-round step.
// ----------------------------------------------------------------------------
package ccb_pkg;

  typedef logic [15:0][31:0] state_t;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] LAST_PHASE = '1;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

  // Quarter-round sub-steps
  localparam logic [1:0] SUB_AD16 = 2'd0;
  localparam logic [1:0] SUB_CB12 = 2'd1;
  localparam logic [1:0] SUB_AD8  = 2'd2;
  localparam logic [1:0] SUB_CB7  = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [31:0] ctr;
  } cell_tag_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // One add/xor/rotate step of all four quarter rounds of a column or diagonal round
  function automatic state_t qr_step(input state_t s, input logic diag, input logic [1:0] sub);
    state_t     r;
    logic [1:0] q2;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    r = s;
    for (int q = 0; q < 4; q++) begin
      q2 = 2'(q);
      ia = {2'b00, q2};
      ib = {2'b01, 2'(q2 + {1'b0, diag})};
      ic = {2'b10, 2'(q2 + {diag, 1'b0})};
      id = {2'b11, 2'(q2 + {diag, diag})};
      case (sub)
        SUB_AD16: begin
          r[ia] = s[ia] + s[ib];
          r[id] = rotl(s[id] ^ r[ia], 16);
        end
        SUB_CB12: begin
          r[ic] = s[ic] + s[id];
          r[ib] = rotl(s[ib] ^ r[ic], 12);
        end
        SUB_AD8: begin
          r[ia] = s[ia] + s[ib];
          r[id] = rotl(s[id] ^ r[ia], 8);
        end
        SUB_CB7: begin
          r[ic] = s[ic] + s[id];
          r[ib] = rotl(s[ib] ^ r[ic], 7);
        end
        default: begin
          r[ia] = s[ia];
        end
      endcase
    end
    return r;
  endfunction

  function automatic state_t build_init(
    input logic [63:0] k0,
    input logic [63:0] k1,
    input logic [63:0] k2,
    input logic [63:0] k3,
    input logic [63:0] nlo,
    input logic [31:0] nhi,
    input logic [31:0] ctr
  );
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr;
    s[13] = nlo[31:0];
    s[14] = nlo[63:32];
    s[15] = nhi;
    return s;
  endfunction

  function automatic state_t add_state(input state_t a, input state_t b);
    state_t s;
    for (int i = 0; i < 16; i++) begin
      s[i] = a[i] + b[i];
    end
    return s;
  endfunction

endpackage

// ===== design/ccb_cell.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 double-round cell
// Holds one block state and runs one double round, one add/xor/rotate step per phase.
// ----------------------------------------------------------------------------
module ccb_cell
  import ccb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [PHASE_W-1:0] phase,
  input  state_t             in_state,
  input  cell_tag_t          in_tag,
  output state_t             out_state,
  output cell_tag_t          out_tag
);

  state_t      state;
  state_t      state_next;
  logic        valid;
  logic [31:0] ctr;
  logic        load;

  assign load       = (phase == LAST_PHASE);
  assign state_next = qr_step(state, phase[2], phase[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      state <= in_state;
      ctr   <= in_tag.ctr;
    end else begin
      state <= state_next;
    end
  end

  // Last step result goes straight to the neighbour
  assign out_state     = state_next;
  assign out_tag.valid = valid;
  assign out_tag.ctr   = ctr;

endmodule

// ===== design/chacha20_block_keystream_unit.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block keystream unit
// Key and nonce come from the config port; each start beat gives one block.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_word0..3, nonce_low and nonce_high through cfg_write/cfg_index/
//   cfg_data while no block is in flight. A beat is taken at a clock edge
//   with start high and busy low; block_counter goes into state word 12.
//   busy is low only on the last phase; a new block can be taken then while
//   earlier blocks are still in the cells. A row of NUM_CELLS double-round
//   cells runs in lockstep on a shared 3-bit phase; each cell does one
//   add/xor/rotate step per cycle and passes its state on at the last phase.
//   The final feed-forward add is one register stage. Each block comes out
//   as eight beats on keystream_valid, word_index 0 to 7, last_word on the
//   eighth, on consecutive cycles. With a start taken at every last phase
//   the output is fully busy.
//   The receiver cannot stall; every beat is shown for one cycle only.
//   Reset clears the phase and every valid flag; config registers reset to 0.
// ----------------------------------------------------------------------------
module chacha20_block_keystream_unit
  import ccb_pkg::*;
#(
  parameter int NUM_CELLS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          block_counter,
  output logic                 keystream_valid,
  output logic [2:0]           word_index,
  output logic [63:0]          keystream_word,
  output logic                 last_word
);

  logic [63:0]        key_word0;
  logic [63:0]        key_word1;
  logic [63:0]        key_word2;
  logic [63:0]        key_word3;
  logic [63:0]        nonce_low;
  logic [31:0]        nonce_high;
  logic [PHASE_W-1:0] phase;
  logic               handoff;
  state_t             chain_state [NUM_CELLS+1];
  cell_tag_t          chain_tag   [NUM_CELLS+1];
  logic               fin_valid;
  state_t             fin_state;
  state_t             fin_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0  <= '0;
      key_word1  <= '0;
      key_word2  <= '0;
      key_word3  <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD0:  key_word0  <= cfg_data;
        REG_KEY_WORD1:  key_word1  <= cfg_data;
        REG_KEY_WORD2:  key_word2  <= cfg_data;
        REG_KEY_WORD3:  key_word3  <= cfg_data;
        REG_NONCE_LOW:  nonce_low  <= cfg_data;
        REG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= phase + 1'b1;
    end
  end

  assign handoff = (phase == LAST_PHASE);
  assign busy    = !handoff;

  assign chain_state[0]   = build_init(key_word0, key_word1, key_word2, key_word3,
                                       nonce_low, nonce_high, block_counter);
  assign chain_tag[0].valid = start;
  assign chain_tag[0].ctr   = block_counter;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    ccb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .phase     (phase),
      .in_state  (chain_state[g]),
      .in_tag    (chain_tag[g]),
      .out_state (chain_state[g+1]),
      .out_tag   (chain_tag[g+1])
    );
  end

  assign fin_state_next = add_state(chain_state[NUM_CELLS],
                                    build_init(key_word0, key_word1, key_word2, key_word3,
                                               nonce_low, nonce_high,
                                               chain_tag[NUM_CELLS].ctr));

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (handoff) begin
      fin_valid <= chain_tag[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      fin_state <= fin_state_next;
    end
  end

  assign keystream_valid = fin_valid;
  assign word_index      = phase;
  assign keystream_word  = {fin_state[{phase, 1'b1}], fin_state[{phase, 1'b0}]};
  assign last_word       = (phase == LAST_PHASE);

endmodule

// ===== design/ccb_checker.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 block keystream checker
// Port-level checks on the start and keystream beats.
// ----------------------------------------------------------------------------
module ccb_checker
  import ccb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       keystream_valid,
  input logic [2:0] word_index,
  input logic       last_word
);

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    keystream_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (keystream_valid && !last_word) |=>
      (keystream_valid && (word_index == 3'($past(word_index) + 3'd1))))
    else $error("keystream beats of one block not consecutive");

  a_block_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(keystream_valid) |-> (word_index == 3'd0))
    else $error("block does not begin at slice 0");

  a_one_slot_in_eight: assert property (@(posedge clk) disable iff (rst)
    (!busy && start) |=> busy)
    else $error("busy low on two consecutive cycles");

endmodule

bind chacha20_block_keystream_unit ccb_checker u_ccb_checker (.*);
